@@ design/lmab_pkg.sv @@
// Shared types and constants of the label map adjacency builder.
// No dependencies; imported by every module of the block.
package lmab_pkg;

  localparam int LBL_W     = 8;   // label width
  localparam int CFG_W     = 11;  // register data width
  localparam int CFG_IDX_W = 2;   // register index width
  localparam int HEIGHT_MAX = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Pair sequencer
  localparam logic [2:0] SEQ_LAST = 3'd5;

  // Window handed from the row stage to the checker
  typedef struct packed {
    logic             is_cmd;
    logic [LBL_W-1:0] ul;
    logic [LBL_W-1:0] left;
    logic [LBL_W-1:0] above;
    logic [LBL_W-1:0] cur;
  } win_tok_t;

  // One edge result
  typedef struct packed {
    logic [LBL_W-1:0] lo;
    logic [LBL_W-1:0] hi;
    logic             last;
  } edge_t;

  // Checker status seen by the row stage
  typedef struct packed {
    logic clearing;
  } ckr_stat_t;

  typedef enum logic [2:0] {
    CK_IDLE  = 3'b001,
    CK_CHECK = 3'b010,
    CK_CLEAR = 3'b100
  } ckr_state_e;

endpackage

@@ design/lmab_window.sv @@
// Row stage: column/row counters, row-above label buffer, 2x2 window build.
// Depends on lmab_pkg.
module lmab_window import lmab_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_cmd_i,
  input  logic [LBL_W-1:0]             in_pixel_label_i,
  input  logic [$clog2(MAX_WIDTH):0]   width_i,
  input  logic [CFG_W-1:0]             height_i,
  output logic                         tok_valid_o,
  input  logic                         tok_ready_i,
  output win_tok_t                     tok_o,
  input  ckr_stat_t                    stat_i
);

  localparam int CI = $clog2(MAX_WIDTH);

  logic [CI-1:0]    col_q, col_d;
  logic [CFG_W-1:0] row_q, row_d;
  logic [LBL_W-1:0] rb_mem [MAX_WIDTH];
  logic [LBL_W-1:0] rb_rd_q;
  logic             s2_v_q, s2_v_d;
  logic             s2_cmd_q, s2_chk_q;
  logic [LBL_W-1:0] s2_cur_q;
  logic [LBL_W-1:0] ul_q, ul_d, lf_q, lf_d;
  logic             accept, pix_live, wrap, chk, s2_move;
  logic [CI:0]      col_inc;

  assign accept   = in_valid_i && !in_stall_o;
  assign pix_live = !in_cmd_i && (row_q < height_i);
  assign col_inc  = {1'b0, col_q} + {{CI{1'b0}}, 1'b1};
  assign wrap     = col_inc >= width_i;
  assign chk      = (row_q != '0) && (col_q != '0);

  assign tok_valid_o = s2_v_q && (s2_cmd_q || s2_chk_q);
  assign tok_o       = '{is_cmd: s2_cmd_q, ul: ul_q, left: lf_q,
                         above: rb_rd_q, cur: s2_cur_q};
  assign s2_move     = s2_v_q && (!(s2_cmd_q || s2_chk_q) || tok_ready_i);
  assign in_stall_o  = stat_i.clearing || (s2_v_q && !s2_move);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    s2_v_d = s2_move ? 1'b0 : s2_v_q;
    ul_d   = ul_q;
    lf_d   = lf_q;
    if (s2_move) begin
      if (s2_cmd_q) begin
        ul_d = '0;
        lf_d = '0;
      end else begin
        ul_d = rb_rd_q;
        lf_d = s2_cur_q;
      end
    end
    if (accept) begin
      if (in_cmd_i) begin
        col_d  = '0;
        row_d  = '0;
        s2_v_d = 1'b1;
      end else if (pix_live) begin
        col_d  = wrap ? '0 : col_inc[CI-1:0];
        row_d  = row_q + CFG_W'(wrap);
        s2_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s2_v_q <= 1'b0;
      ul_q   <= '0;
      lf_q   <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s2_v_q <= s2_v_d;
      ul_q   <= ul_d;
      lf_q   <= lf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_cmd_q <= in_cmd_i;
      s2_chk_q <= chk;
      s2_cur_q <= in_pixel_label_i;
    end
  end

  // Row buffer: read old label and write the new one at the same column.
  always_ff @(posedge clk_i) begin
    if (accept && pix_live) begin
      rb_rd_q        <= rb_mem[col_q];
      rb_mem[col_q]  <= in_pixel_label_i;
    end
  end

endmodule

@@ design/lmab_checker.sv @@
// Pair checker: adjacency bitmap memory, six-pair sequencer, clear sweep.
// Depends on lmab_pkg.
module lmab_checker import lmab_pkg::*; #(
  parameter int MAX_LABELS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_valid_i,
  output logic                 tok_ready_o,
  input  win_tok_t             tok_i,
  input  logic [OUT_CNT_W-1:0] fifo_cnt_i,
  output logic                 push_o,
  output edge_t                push_data_o,
  output ckr_stat_t            stat_o
);

  localparam int RW = $clog2(MAX_LABELS);

  ckr_state_e        state_q, state_d;
  logic [2:0]        seq_q, seq_d;
  logic [RW-1:0]     clr_q, clr_d;
  logic [LBL_W-1:0]  ul_q, lf_q, ab_q, cu_q;
  logic [LBL_W-1:0]  pa, pb, p_lo, p_hi;
  logic              p_ok;
  logic              res_v_q, res_ok_q, res_last_q;
  logic [LBL_W-1:0]  res_lo_q, res_hi_q;
  logic              pend_v_q, pend_v_d, pend_done_q, pend_done_d;
  logic [LBL_W-1:0]  pend_lo_q, pend_lo_d, pend_hi_q, pend_hi_d;
  logic [MAX_LABELS-1:0] adj_mem [MAX_LABELS];
  logic [MAX_LABELS-1:0] rd_q, fwd_data_q, row_data, wr_data;
  logic              fwd_v_q;
  logic [RW-1:0]     rd_addr, wr_addr, hi_idx;
  logic              wr_en, hit, can_issue, issue, last_issue, tok_take;
  logic [31:0]       p_lo32, p_hi32, res_lo32, res_hi32;

  always_comb begin
    unique case (seq_q)
      3'd0:    begin pa = ul_q; pb = lf_q; end
      3'd1:    begin pa = ul_q; pb = ab_q; end
      3'd2:    begin pa = ul_q; pb = cu_q; end
      3'd3:    begin pa = ab_q; pb = lf_q; end
      3'd4:    begin pa = ab_q; pb = cu_q; end
      default: begin pa = lf_q; pb = cu_q; end
    endcase
  end

  assign p_lo   = (pa < pb) ? pa : pb;
  assign p_hi   = (pa < pb) ? pb : pa;
  assign p_lo32 = 32'(p_lo);
  assign p_hi32 = 32'(p_hi);
  assign p_ok   = (p_lo != p_hi) && (p_hi32 < 32'(MAX_LABELS));

  // Reserve an output slot for every check in flight.
  assign can_issue  = (32'(fifo_cnt_i) + 32'(res_v_q) + 32'(pend_v_q) + 32'd1)
                      <= 32'(OUT_DEPTH);
  assign issue      = (state_q == CK_CHECK) && can_issue;
  assign last_issue = issue && (seq_q == SEQ_LAST);

  assign tok_ready_o = ((state_q == CK_IDLE) && (!tok_i.is_cmd || !res_v_q)) ||
                       (last_issue && !tok_i.is_cmd);
  assign tok_take    = tok_valid_i && tok_ready_o;
  assign stat_o.clearing = (state_q == CK_CLEAR);

  always_comb begin
    state_d = state_q;
    seq_d   = seq_q;
    clr_d   = clr_q;
    unique case (state_q)
      CK_CLEAR: begin
        clr_d = clr_q + RW'(1);
        if (clr_q == RW'(MAX_LABELS - 1)) state_d = CK_IDLE;
      end
      CK_IDLE, CK_CHECK: begin
        if (tok_take) begin
          if (tok_i.is_cmd) begin
            state_d = CK_CLEAR;
            clr_d   = '0;
          end else begin
            state_d = CK_CHECK;
            seq_d   = '0;
          end
        end else if (last_issue) begin
          state_d = CK_IDLE;
        end else if (issue) begin
          seq_d = seq_q + 3'd1;
        end
      end
      default: state_d = CK_IDLE;
    endcase
  end

  // Resolve stage: bypass a row written in the cycle of its read.
  assign res_lo32 = 32'(res_lo_q);
  assign res_hi32 = 32'(res_hi_q);
  assign hi_idx   = res_hi32[RW-1:0];
  assign row_data = fwd_v_q ? fwd_data_q : rd_q;
  assign hit      = res_v_q && res_ok_q && !row_data[hi_idx];
  assign rd_addr  = p_lo32[RW-1:0];

  always_comb begin
    if (state_q == CK_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = hit;
      wr_addr = res_lo32[RW-1:0];
      wr_data = row_data | ({{(MAX_LABELS-1){1'b0}}, 1'b1} << hi_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) adj_mem[wr_addr] <= wr_data;
    rd_q       <= adj_mem[rd_addr];
    fwd_data_q <= wr_data;
  end

  // Pending edge: held until the next edge or the end of its pixel sets last.
  assign push_o      = pend_v_q && (pend_done_q || hit);
  assign push_data_o = '{lo: pend_lo_q, hi: pend_hi_q, last: pend_done_q};

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_done_d = pend_done_q;
    pend_lo_d   = pend_lo_q;
    pend_hi_d   = pend_hi_q;
    if (hit) begin
      pend_v_d    = 1'b1;
      pend_done_d = res_last_q;
      pend_lo_d   = res_lo_q;
      pend_hi_d   = res_hi_q;
    end else if (push_o) begin
      pend_v_d = 1'b0;
    end else if (res_v_q && res_last_q && pend_v_q) begin
      pend_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CK_CLEAR;
      seq_q       <= '0;
      clr_q       <= '0;
      res_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      pend_done_q <= 1'b0;
      fwd_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      clr_q       <= clr_d;
      res_v_q     <= issue;
      pend_v_q    <= pend_v_d;
      pend_done_q <= pend_done_d;
      fwd_v_q     <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_lo_q <= pend_lo_d;
    pend_hi_q <= pend_hi_d;
    if (issue) begin
      res_ok_q   <= p_ok;
      res_lo_q   <= p_lo;
      res_hi_q   <= p_hi;
      res_last_q <= (seq_q == SEQ_LAST);
    end
    if (tok_take && !tok_i.is_cmd) begin
      ul_q <= tok_i.ul;
      lf_q <= tok_i.left;
      ab_q <= tok_i.above;
      cu_q <= tok_i.cur;
    end
  end

endmodule

@@ design/lmab_out_fifo.sv @@
// Small edge result queue in front of the output port.
// Depends on lmab_pkg.
module lmab_out_fifo import lmab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  edge_t                push_data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output edge_t                head_o,
  output logic [OUT_CNT_W-1:0] cnt_o
);

  edge_t                 ent_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0]  cnt_q;

  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      cnt_q <= cnt_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ design/label_map_adjacency_builder.sv @@
// Region adjacency builder: top level with config registers and assertions.
// The row stage registers each pixel item and forms its window; the checker
// issues the six pairs in turn (one bitmap row read per pair on the single
// checker port) while the row stage holds the next window. A new edge is held
// until the next edge or the end of its pixel, then queued. Pixels closing no
// 2x2 window skip the checker. Reset and new-frame items clear all MAX_LABELS
// bitmap rows in a sweep, stalling input. Config registers reset to 640 x 480.
module label_map_adjacency_builder import lmab_pkg::*; #(
  parameter int MAX_LABELS = 256,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_cmd_i,
  input  logic [LBL_W-1:0]     in_pixel_label_i,
  // edge items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LBL_W-1:0]     out_label_low_o,
  output logic [LBL_W-1:0]     out_label_high_o,
  output logic                 out_last_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CI = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0]     width_q, height_q;
  logic [31:0]          w32, h32, w_eff32, h_eff32;
  logic [CI:0]          w_eff;
  logic [CFG_W-1:0]     h_eff;
  logic                 tok_valid, tok_ready, push, pop;
  win_tok_t             tok;
  edge_t                push_data, head;
  ckr_stat_t            stat;
  logic [OUT_CNT_W-1:0] fifo_cnt;

  // Config registers: always ready; to be written only while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate frame size to the supported range.
  assign w32     = 32'(width_q);
  assign h32     = 32'(height_q);
  assign w_eff32 = (w32 < 32'd2) ? 32'd2 :
                   ((w32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w32);
  assign h_eff32 = (h32 < 32'd2) ? 32'd2 :
                   ((h32 > 32'(HEIGHT_MAX)) ? 32'(HEIGHT_MAX) : h32);
  assign w_eff   = w_eff32[CI:0];
  assign h_eff   = h_eff32[CFG_W-1:0];

  // Counters and row-above buffer; forms a window for each pixel past row 0 and column 0.
  lmab_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_pixel_label_i (in_pixel_label_i),
    .width_i          (w_eff),
    .height_i         (h_eff),
    .tok_valid_o      (tok_valid),
    .tok_ready_i      (tok_ready),
    .tok_o            (tok),
    .stat_i           (stat)
  );

  // Bitmap read-modify-write over the six pairs of each window.
  lmab_checker #(.MAX_LABELS(MAX_LABELS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_ready_o (tok_ready),
    .tok_i       (tok),
    .fifo_cnt_i  (fifo_cnt),
    .push_o      (push),
    .push_data_o (push_data),
    .stat_o      (stat)
  );

  // Output queue decouples the checker from the stall on the edge side.
  assign pop = out_valid_o && !out_stall_i;

  lmab_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .head_o      (head),
    .cnt_o       (fifo_cnt)
  );

  assign out_label_low_o  = head.lo;
  assign out_label_high_o = head.hi;
  assign out_last_o       = head.last;

  // Slot reservation must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((32'(fifo_cnt) < 32'(OUT_DEPTH)) || pop))
    else $error("edge queue overflow");

  // No pixel is taken while the bitmap sweep runs.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !stat.clearing)
    else $error("item accepted during bitmap clear");

  // Edges always come ordered, smaller label first.
  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_label_low_o < out_label_high_o))
    else $error("edge labels out of order");

endmodule

@@ dv/tb_label_map_adjacency_builder.sv @@
// Self-checking testbench for label_map_adjacency_builder.
// Streams label maps, predicts the edge items in the bench, compares in order.
// Depends on lmab_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_label_map_adjacency_builder;
  import lmab_pkg::*;

  localparam int NUM_LBL       = 256;
  localparam int ROW_MAX       = 1024;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 300;   // covers the bitmap clear sweep
  localparam int LONG_HOLD     = 300;   // receiver hold-off, in cycles

  typedef struct {
    bit       cmd;
    bit [7:0] lbl;
  } pixel_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 in_cmd_i = 1'b0;
  logic [LBL_W-1:0]     in_pixel_label_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [LBL_W-1:0]     out_label_low_o;
  logic [LBL_W-1:0]     out_label_high_o;
  logic                 out_last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  label_map_adjacency_builder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_pixel_label_i (in_pixel_label_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_label_low_o  (out_label_low_o),
    .out_label_high_o (out_label_high_o),
    .out_last_o       (out_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Adjacency predictor: bench-side copy of the block's state.
  // ---------------------------------------------------------------------------
  bit          seen_pair [NUM_LBL*NUM_LBL];
  bit [7:0]    prev_row  [ROW_MAX];
  bit [7:0]    left_lbl, ul_lbl;
  int unsigned col_cnt, row_cnt;
  bit [10:0]   width_reg = 11'd640;
  bit [10:0]   height_reg = 11'd480;

  edge_t       edge_q[$];      // edges still owed by the block
  pixel_item_t pixel_q[$];     // items waiting for the driver
  pixel_item_t next_pix;
  int          mismatches = 0;

  function automatic int unsigned clamp_dim(bit [10:0] v);
    if (v < 2) return 2;
    if (v > 1024) return 1024;
    return v;
  endfunction

  // Mark an unordered pair; queue an edge if it is new. Returns edges queued.
  function automatic int mark_pair(bit [7:0] a, bit [7:0] b);
    bit [7:0] lo, hi;
    edge_t    e;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi || seen_pair[lo*NUM_LBL + hi]) return 0;
    seen_pair[lo*NUM_LBL + hi] = 1'b1;
    e.lo = lo;
    e.hi = hi;
    e.last = 1'b0;
    edge_q.push_back(e);
    return 1;
  endfunction

  function automatic void clear_frame_state();
    foreach (seen_pair[i]) seen_pair[i] = 1'b0;
    left_lbl = '0;
    ul_lbl = '0;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic void predict_edges(bit cmd, bit [7:0] cur);
    int unsigned w, h, c;
    bit [7:0]    above;
    int          n;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    n = 0;
    if (cmd) begin
      clear_frame_state();
      return;
    end
    if (row_cnt >= h) return;  // past the frame: ignored
    c = col_cnt % ROW_MAX;
    above = prev_row[c];
    if (row_cnt >= 1 && c >= 1) begin
      // window order: ul-left, ul-above, ul-cur, above-left, above-cur, left-cur
      n += mark_pair(ul_lbl, left_lbl);
      n += mark_pair(ul_lbl, above);
      n += mark_pair(ul_lbl, cur);
      n += mark_pair(above, left_lbl);
      n += mark_pair(above, cur);
      n += mark_pair(left_lbl, cur);
      if (n > 0) edge_q[$].last = 1'b1;
    end
    ul_lbl = above;
    left_lbl = cur;
    prev_row[c] = cur;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shaping knobs, set by the stimulus process.
  // ---------------------------------------------------------------------------
  int unsigned src_idle_pct = 0;
  int unsigned dst_stall_pct = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_cnt = 0;

  // Pixel driver: offers the next queued item once the current one is taken.
  // Valid only depends on the idle draw, never on stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_edges(in_cmd_i, in_pixel_label_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          next_pix = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          in_cmd_i <= next_pix.cmd;
          in_pixel_label_i <= next_pix.lbl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Edge receiver stall; one long hold-off lets the block back up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= LONG_HOLD) long_hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < dst_stall_pct);
    end
  end

  // Edge monitor: in-order compare against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (edge_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected edge lo=%0d hi=%0d last=%0d", $realtime,
                 out_label_low_o, out_label_high_o, out_last_o);
      end else begin
        if (out_label_low_o !== edge_q[0].lo || out_label_high_o !== edge_q[0].hi ||
            out_last_o !== edge_q[0].last) begin
          mismatches++;
          $display("%0t: edge mismatch exp lo=%0d hi=%0d last=%0d got lo=%0d hi=%0d last=%0d",
                   $realtime, edge_q[0].lo, edge_q[0].hi, edge_q[0].last,
                   out_label_low_o, out_label_high_o, out_last_o);
        end
        void'(edge_q.pop_front());
      end
    end
  end

  // Watchdog: ends the run if no channel moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL label_map_adjacency_builder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [10:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic push_pix(bit cmd, bit [7:0] lbl);
    pixel_item_t p;
    p.cmd = cmd;
    p.lbl = lbl;
    pixel_q.push_back(p);
  endtask

  // Everything sent, every edge back, then let the block settle.
  task automatic drain();
    do @(posedge clk_i); while (pixel_q.size() != 0 || in_valid_i || edge_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Frame of npix pixels drawn from a label window of base..base+span (wrapping);
  // a few labels are forced to the extremes.
  task automatic push_frame(int npix, bit [7:0] base, int span);
    int k;
    push_pix(1'b1, 8'($urandom_range(255)));
    for (k = 0; k < npix; k++) begin
      case ($urandom_range(19))
        0:       push_pix(1'b0, 8'd0);
        1:       push_pix(1'b0, 8'd255);
        default: push_pix(1'b0, 8'(base + $urandom_range(span)));
      endcase
    end
  endtask

  task automatic random_frame();
    int unsigned w, h, npix;
    w = $urandom_range(6, 2);
    h = $urandom_range(5, 2);
    npix = w * h;
    case ($urandom_range(7))
      0:       npix = $urandom_range(npix - 1, 1);  // cut short by the next frame
      1:       npix = npix + $urandom_range(4, 1);  // trailing pixels to be ignored
      default: ;
    endcase
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'(w));
    write_reg(REG_IMAGE_HEIGHT, 11'(h));
    push_frame(npix, 8'($urandom_range(255)),
               ($urandom_range(3) == 0) ? 255 : $urandom_range(12, 3));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph, f;
    clear_frame_state();
    foreach (prev_row[i]) prev_row[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // Directed: smallest frame, label extremes, equal labels, trailing pixels.
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    push_pix(1'b1, 8'd255);                      // new frame, label ignored
    push_pix(1'b0, 8'd0);   push_pix(1'b0, 8'd255);
    push_pix(1'b0, 8'd255); push_pix(1'b0, 8'd0);
    push_pix(1'b0, 8'd17);  push_pix(1'b0, 8'd34);  // past the frame
    push_pix(1'b1, 8'd0);                        // all six pairs distinct
    push_pix(1'b0, 8'd40);  push_pix(1'b0, 8'd30);
    push_pix(1'b0, 8'd20);  push_pix(1'b0, 8'd10);
    push_pix(1'b1, 8'd0);                        // uniform window: no edges
    push_pix(1'b0, 8'd170); push_pix(1'b0, 8'd170);
    push_pix(1'b0, 8'd170); push_pix(1'b0, 8'd170);
    drain();
    // Out-of-range dims saturate to 2x2.
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    push_pix(1'b1, 8'd85);
    push_pix(1'b0, 8'd10);  push_pix(1'b0, 8'd20);
    push_pix(1'b0, 8'd10);  push_pix(1'b0, 8'd20);
    drain();

    // Widest row (saturated from 2047): the start of row zero only.
    write_reg(REG_IMAGE_WIDTH, 11'd2047);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    push_frame(30, 8'd0, 255);
    drain();
    // Receiver holds off for a long stretch while the sender keeps offering.
    write_reg(REG_IMAGE_WIDTH, 11'd8);
    write_reg(REG_IMAGE_HEIGHT, 11'd8);
    long_hold_req = 1'b1;
    push_frame(64, 8'd0, 255);
    drain();
    // Tallest frame, only a few rows of it before the next new-frame.
    write_reg(REG_IMAGE_WIDTH, 11'd1024);
    write_reg(REG_IMAGE_HEIGHT, 11'd1024);
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd2047);
    push_frame(24, 8'd100, 9);

    // Random frames under each traffic profile.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin src_idle_pct = 79; dst_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  dst_stall_pct = 79; end
        3:       begin src_idle_pct = 12; dst_stall_pct = 12; end
        default: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
      endcase
      for (f = 0; f < 3; f++) random_frame();
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS label_map_adjacency_builder");
    end else begin
      $display("FAIL label_map_adjacency_builder");
    end
    $finish;
  end

endmodule
